// File: hw/rtl/arp_cache_table_assert.svh
// Assertion macros shared by the ARP cache RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ARP_CACHE_TABLE_ASSERT_SVH
`define ARP_CACHE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define ARPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ARPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/arpc_pkg.sv
// Shared types and codes for the ARP cache table.
// No dependencies; imported by arpc_cell and arp_cache_table.
`timescale 1ns / 1ps

package arpc_pkg;

  localparam logic [1:0] ENT_EMPTY   = 2'd0;
  localparam logic [1:0] ENT_STABLE  = 2'd1;
  localparam logic [1:0] ENT_PENDING = 2'd2;

  localparam logic [1:0] RES_OK   = 2'd0;
  localparam logic [1:0] RES_MISS = 2'd1;
  localparam logic [1:0] RES_FULL = 2'd2;

  localparam logic KIND_UPDATE  = 1'b0;
  localparam logic KIND_RESOLVE = 1'b1;

  // Search state handed from cell to cell
  typedef struct packed {
    logic        found_match;
    logic        found_stable;
    logic        found_empty;
    logic [47:0] stable_mac;
  } probe_t;

  // Entry write broadcast to all cells
  typedef struct packed {
    logic        en;
    logic        set_mac;
    logic [1:0]  state;
    logic [31:0] ip;
    logic [47:0] mac;
  } wr_t;

endpackage

// File: hw/rtl/arpc_cell.sv
// One ARP cache entry plus its stage of the lookup chain.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_cell
  import arpc_pkg::*;
#(
  parameter int unsigned      IDX_W = 4,
  parameter logic [IDX_W-1:0] IDX   = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      key_ip,
  input  probe_t           probe_in,
  input  logic [IDX_W-1:0] match_idx_in,
  input  logic [IDX_W-1:0] stable_idx_in,
  input  logic [IDX_W-1:0] empty_idx_in,
  output probe_t           probe_out,
  output logic [IDX_W-1:0] match_idx_out,
  output logic [IDX_W-1:0] stable_idx_out,
  output logic [IDX_W-1:0] empty_idx_out,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] wr_idx
);

  logic [31:0]      ip_r;
  logic [47:0]      mac_r;
  logic [1:0]       state_r;
  probe_t           probe_r, probe_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic [IDX_W-1:0] stable_idx_r, stable_idx_nxt;
  logic [IDX_W-1:0] empty_idx_r, empty_idx_nxt;
  logic             ip_eq, is_empty, is_stable;

  always_comb begin
    ip_eq     = (ip_r == key_ip);
    is_empty  = (state_r == ENT_EMPTY);
    is_stable = (state_r == ENT_STABLE);

    probe_nxt.found_match  = probe_in.found_match | (!is_empty & ip_eq);
    probe_nxt.found_stable = probe_in.found_stable | (is_stable & ip_eq);
    probe_nxt.found_empty  = probe_in.found_empty | is_empty;
    probe_nxt.stable_mac   = probe_in.found_stable ? probe_in.stable_mac : mac_r;

    match_idx_nxt  = probe_in.found_match  ? match_idx_in  : IDX;
    stable_idx_nxt = probe_in.found_stable ? stable_idx_in : IDX;
    empty_idx_nxt  = probe_in.found_empty  ? empty_idx_in  : IDX;
  end

  always_ff @(posedge clk) begin
    probe_r      <= probe_nxt;
    match_idx_r  <= match_idx_nxt;
    stable_idx_r <= stable_idx_nxt;
    empty_idx_r  <= empty_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ENT_EMPTY;
    end else if (wr.en && (wr_idx == IDX)) begin
      state_r <= wr.state;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == IDX)) begin
      ip_r <= wr.ip;
      if (wr.set_mac) begin
        mac_r <= wr.mac;
      end
    end
  end

  assign probe_out      = probe_r;
  assign match_idx_out  = match_idx_r;
  assign stable_idx_out = stable_idx_r;
  assign empty_idx_out  = empty_idx_r;

endmodule

// File: hw/rtl/arp_cache_table.sv
// ARP cache of TABLE_ENTRIES entries kept in a chain of cells. A request
// is taken only while the block is idle; its lookup then walks the chain
// one cell per cycle, and the update or claim is written when the walk
// has passed the last cell; no new request is taken before that write.
// The result sits in an output register, so the next request is taken
// while it waits; the write back stalls only while that register is still
// full and out_stall is high. After reset every entry is empty and
// requests are taken at once.
// Depends on arpc_pkg, arpc_cell and arp_cache_table_assert.svh.
`timescale 1ns / 1ps

module arp_cache_table
  import arpc_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_ip_addr,
  input  logic [47:0] in_mac_addr,
  input  logic        in_is_request,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_status,
  output logic [47:0] out_found_mac,
  output logic [3:0]  out_slot,
  output logic        out_send_query,
  output logic        out_send_reply
);

  `include "arp_cache_table_assert.svh"

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  logic        kind_r;
  logic [31:0] ip_r;
  logic [47:0] mac_r;
  logic        req_r;

  probe_t           probe_c    [TABLE_ENTRIES+1];
  logic [IDX_W-1:0] match_idx  [TABLE_ENTRIES+1];
  logic [IDX_W-1:0] stable_idx [TABLE_ENTRIES+1];
  logic [IDX_W-1:0] empty_idx  [TABLE_ENTRIES+1];

  wr_t              wr;
  logic [IDX_W-1:0] wr_idx;

  logic        out_valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [47:0] fmac_r, fmac_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic        query_r, query_nxt;
  logic        reply_r, reply_nxt;

  logic             accept, out_free, commit, target_ok;
  logic [IDX_W-1:0] target_idx, slot_idx;
  logic [IDX_W+3:0] slot_ext;
  probe_t           fin;

  assign probe_c[0]    = '0;
  assign match_idx[0]  = '0;
  assign stable_idx[0] = '0;
  assign empty_idx[0]  = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    arpc_cell #(
      .IDX_W (IDX_W),
      .IDX   (IDX_W'(g))
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .key_ip         (ip_r),
      .probe_in       (probe_c[g]),
      .match_idx_in   (match_idx[g]),
      .stable_idx_in  (stable_idx[g]),
      .empty_idx_in   (empty_idx[g]),
      .probe_out      (probe_c[g+1]),
      .match_idx_out  (match_idx[g+1]),
      .stable_idx_out (stable_idx[g+1]),
      .empty_idx_out  (empty_idx[g+1]),
      .wr             (wr),
      .wr_idx         (wr_idx)
    );
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == S_DONE) && out_free;
  assign fin      = probe_c[TABLE_ENTRIES];

  always_comb begin
    target_ok  = fin.found_match | fin.found_empty;
    target_idx = fin.found_match ? match_idx[TABLE_ENTRIES] : empty_idx[TABLE_ENTRIES];

    wr.en      = 1'b0;
    wr.set_mac = 1'b0;
    wr.state   = ENT_STABLE;
    wr.ip      = ip_r;
    wr.mac     = mac_r;
    wr_idx     = target_idx;

    status_nxt = RES_FULL;
    fmac_nxt   = '0;
    slot_idx   = '0;
    query_nxt  = 1'b0;
    reply_nxt  = 1'b0;

    if (kind_r == KIND_UPDATE) begin
      reply_nxt = req_r;
      if (target_ok) begin
        wr.en      = commit;
        wr.set_mac = 1'b1;
        wr.state   = ENT_STABLE;
        status_nxt = RES_OK;
        slot_idx   = target_idx;
      end
    end else if (fin.found_stable) begin
      status_nxt = RES_OK;
      fmac_nxt   = fin.stable_mac;
      slot_idx   = stable_idx[TABLE_ENTRIES];
    end else if (target_ok) begin
      wr.en      = commit;
      wr.state   = ENT_PENDING;
      status_nxt = RES_MISS;
      query_nxt  = 1'b1;
      slot_idx   = target_idx;
    end

    slot_ext = {4'b0, slot_idx};
    slot_nxt = slot_ext[3:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r == LAST_CELL) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      ip_r   <= in_ip_addr;
      mac_r  <= in_mac_addr;
      req_r  <= in_is_request;
    end
    if (commit) begin
      status_r <= status_nxt;
      fmac_r   <= fmac_nxt;
      slot_r   <= slot_nxt;
      query_r  <= query_nxt;
      reply_r  <= reply_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_status = status_r;
  assign out_found_mac     = fmac_r;
  assign out_slot          = slot_r;
  assign out_send_query    = query_r;
  assign out_send_reply    = reply_r;

  `ARPC_ASSERT_NEXT(a_accept_scans, clk, rst_n, accept, state_r == S_SCAN, "accept did not start scan")
  `ARPC_ASSERT_NEXT(a_commit_shows, clk, rst_n, commit, out_valid_r, "committed result not shown")
  `ARPC_ASSERT_NOW(a_cnt_bound, clk, rst_n, state_r == S_SCAN, cnt_r <= LAST_CELL, "scan count past end")
  `ARPC_ASSERT_NOW(a_full_quiet, clk, rst_n, out_valid_r && (status_r == RES_FULL), (slot_r == 4'd0) && (fmac_r == 48'd0) && !query_r, "full result carries data")
  `ARPC_ASSERT_NOW(a_full_no_write, clk, rst_n, commit && (status_nxt == RES_FULL), !wr.en, "write on full table")

endmodule

// File: tb/testbench.sv
// Self-checking bench for arp_cache_table: directed table, then random update/resolve traffic.
// Predicts results from a cache copy unless a row gives one; depends on arpc_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import arpc_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int RANDOM_ITEMS  = 1125;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic        kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic        is_request;
  } arp_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] mac;
    logic [3:0]  slot;
    logic        query;
    logic        reply;
  } arp_res_t;

  typedef struct {
    arp_req_t req;
    bit       has_golden;
    arp_res_t golden;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [31:0] in_ip_addr;
  logic [47:0] in_mac_addr;
  logic        in_is_request;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_status;
  logic [47:0] out_found_mac;
  logic [3:0]  out_slot;
  logic        out_send_query;
  logic        out_send_reply;

  logic [31:0] cache_ip    [TABLE_ENTRIES];
  logic [47:0] cache_mac   [TABLE_ENTRIES];
  logic [1:0]  cache_state [TABLE_ENTRIES];

  arp_res_t awaited_results [$];
  dir_row_t directed_rows [$];

  bit idle_en = 1'b1;
  int cycle_count = 0;
  int err_count   = 0;
  int sent_count  = 0;
  int ok_count    = 0;
  int miss_count  = 0;
  int full_count  = 0;

  arp_cache_table u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_ip_addr        (in_ip_addr),
    .in_mac_addr       (in_mac_addr),
    .in_is_request     (in_is_request),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_status (out_result_status),
    .out_found_mac     (out_found_mac),
    .out_slot          (out_slot),
    .out_send_query    (out_send_query),
    .out_send_reply    (out_send_reply)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // First non-empty entry with this IP, else lowest empty; -1 when full
  function automatic int cache_slot_for(logic [31:0] ip);
    int empty_idx;
    empty_idx = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (cache_state[i] == ENT_EMPTY) begin
        if (empty_idx < 0) empty_idx = i;
      end else if (cache_ip[i] == ip) begin
        return i;
      end
    end
    return empty_idx;
  endfunction

  function automatic arp_res_t cache_access(arp_req_t r);
    arp_res_t res;
    int idx;
    res = '0;
    idx = -1;
    if (r.kind == KIND_UPDATE) begin
      res.reply = r.is_request;
      idx = cache_slot_for(r.ip);
      if (idx < 0) begin
        res.status = RES_FULL;
      end else begin
        cache_ip[idx]    = r.ip;
        cache_mac[idx]   = r.mac;
        cache_state[idx] = ENT_STABLE;
        res.status       = RES_OK;
        res.slot         = idx[3:0];
      end
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (idx < 0 && cache_state[i] == ENT_STABLE && cache_ip[i] == r.ip) idx = i;
      end
      if (idx >= 0) begin
        res.status = RES_OK;
        res.mac    = cache_mac[idx];
        res.slot   = idx[3:0];
      end else begin
        idx = cache_slot_for(r.ip);
        if (idx < 0) begin
          res.status = RES_FULL;
        end else begin
          cache_ip[idx]    = r.ip;
          cache_state[idx] = ENT_PENDING;
          res.status       = RES_MISS;
          res.query        = 1'b1;
          res.slot         = idx[3:0];
        end
      end
    end
    return res;
  endfunction

  task automatic add_row(input logic kind, input logic [31:0] ip, input logic [47:0] mac,
                         input logic is_request, input bit has_golden, input arp_res_t golden);
    dir_row_t row;
    row.req        = {kind, ip, mac, is_request};
    row.has_golden = has_golden;
    row.golden     = golden;
    directed_rows.push_back(row);
  endtask

  // Drive one request at the falling edge and hold it until taken
  task automatic issue_request(input arp_req_t r, input bit has_golden,
                               input arp_res_t golden);
    arp_res_t predicted;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= r.kind;
    in_ip_addr    <= r.ip;
    in_mac_addr   <= r.mac;
    in_is_request <= r.is_request;
    do @(posedge clk); while (in_stall);
    predicted = cache_access(r);
    awaited_results.push_back(has_golden ? golden : predicted);
    sent_count++;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    arp_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      case (out_result_status)
        RES_OK:   ok_count++;
        RES_MISS: miss_count++;
        default:  full_count++;
      endcase
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding: status %0d slot %0d",
               out_result_status, out_slot);
        err_count++;
      end else begin
        exp_res = awaited_results.pop_front();
        if (out_result_status !== exp_res.status) begin
          $error("result_status expected %0d got %0d", exp_res.status, out_result_status);
          err_count++;
        end
        if (out_found_mac !== exp_res.mac) begin
          $error("found_mac expected %h got %h", exp_res.mac, out_found_mac);
          err_count++;
        end
        if (out_slot !== exp_res.slot) begin
          $error("slot expected %0d got %0d", exp_res.slot, out_slot);
          err_count++;
        end
        if (out_send_query !== exp_res.query) begin
          $error("send_query expected %0d got %0d", exp_res.query, out_send_query);
          err_count++;
        end
        if (out_send_reply !== exp_res.reply) begin
          $error("send_reply expected %0d got %0d", exp_res.reply, out_send_reply);
          err_count++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, awaited_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    arp_req_t req;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_UPDATE;
    in_ip_addr    = '0;
    in_mac_addr   = '0;
    in_is_request = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      cache_ip[i]    = '0;
      cache_mac[i]   = '0;
      cache_state[i] = ENT_EMPTY;
    end

    // empty table: resolve claims slot 0, a repeat keeps it pending
    add_row(KIND_RESOLVE, 32'h0, 48'hA5A5_A5A5_A5A5, 1'b1, 1'b1,
            {RES_MISS, 48'h0, 4'd0, 1'b1, 1'b0});
    add_row(KIND_RESOLVE, 32'h0, 48'h0, 1'b0, 1'b1,
            {RES_MISS, 48'h0, 4'd0, 1'b1, 1'b0});
    add_row(KIND_UPDATE, 32'h0, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1,
            {RES_OK, 48'h0, 4'd0, 1'b0, 1'b1});
    add_row(KIND_RESOLVE, 32'h0, 48'h0, 1'b1, 1'b1,
            {RES_OK, 48'hFFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b0});
    add_row(KIND_UPDATE, 32'hFFFF_FFFF, 48'h0, 1'b0, 1'b1,
            {RES_OK, 48'h0, 4'd1, 1'b0, 1'b0});
    add_row(KIND_RESOLVE, 32'hFFFF_FFFF, 48'h5A5A_5A5A_5A5A, 1'b0, 1'b1,
            {RES_OK, 48'h0, 4'd1, 1'b0, 1'b0});
    for (int i = 0; i < TABLE_ENTRIES - 2; i++) begin
      add_row(KIND_RESOLVE, 32'h0A00_0000 + i, 48'h0, i[0], 1'b0, '0);
    end
    // table now full
    add_row(KIND_UPDATE, 32'hDEAD_BEEF, 48'h1234_5678_9ABC, 1'b1, 1'b1,
            {RES_FULL, 48'h0, 4'd0, 1'b0, 1'b1});
    add_row(KIND_UPDATE, 32'hDEAD_BEEF, 48'h1234_5678_9ABC, 1'b0, 1'b1,
            {RES_FULL, 48'h0, 4'd0, 1'b0, 1'b0});
    add_row(KIND_RESOLVE, 32'hDEAD_BEEF, 48'h0, 1'b1, 1'b1,
            {RES_FULL, 48'h0, 4'd0, 1'b0, 1'b0});
    add_row(KIND_RESOLVE, 32'h0A00_0003, 48'h0, 1'b0, 1'b0, '0);
    add_row(KIND_UPDATE, 32'h0A00_0003, 48'h8000_0000_0001, 1'b0, 1'b0, '0);
    add_row(KIND_RESOLVE, 32'h0A00_0003, 48'h0, 1'b0, 1'b0, '0);
    add_row(KIND_UPDATE, 32'h0, 48'h0123_4567_89AB, 1'b0, 1'b0, '0);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      issue_request(directed_rows[k].req, directed_rows[k].has_golden,
                    directed_rows[k].golden);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_en = !((i >= 300 && i < 400) || i >= RANDOM_ITEMS - 150);
      if (i == 550) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge clk);
      end
      req.kind       = 1'($urandom_range(0, 1));
      req.ip         = ($urandom_range(0, 4) == 0) ? $urandom
                       : cache_ip[$urandom_range(0, TABLE_ENTRIES - 1)];
      req.mac[47:32] = 16'($urandom_range(0, 16'hFFFF));
      req.mac[31:0]  = $urandom;
      req.is_request = 1'($urandom_range(0, 1));
      issue_request(req, 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (2 * TABLE_ENTRIES + 10) @(posedge clk);

    $display("%0d requests (%0d directed) through fill, pending, hit and full cases",
             sent_count, directed_rows.size());
    $display("results: %0d hit/updated, %0d pending miss, %0d table full, %0d errors",
             ok_count, miss_count, full_count, err_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_cell.sv
hw/rtl/arp_cache_table.sv
tb/testbench.sv
